### sv/nps_pkg.sv
// Package for the nearest point search: sizes, operation codes and register map.
`default_nettype none

package nps_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 64;
  localparam int COORD_BITS  = 16;

  // Fixed field widths of the request and result ports
  localparam int OP_W        = 1;
  localparam int ENTRY_IDX_W = 6;
  localparam int COORD_IN_W  = 16;
  localparam int AREA_W      = 16;
  localparam int SCOUNT_W    = 7;

  // Derived sizes
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ROW_W  = 2 * COORD_BITS;
  localparam int DIFF_W = (COORD_BITS > AREA_W) ? COORD_BITS : AREA_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DIST_W = SQ_W + 1;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = 2;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_AREA_WIDTH   = 2'd0,
    REG_AREA_HEIGHT  = 2'd1,
    REG_SENDER_COUNT = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_sel_e;

  // Request operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // Reset values of the configuration registers
  localparam logic [AREA_W-1:0]   AREA_WIDTH_RST   = 16'hFFFF;
  localparam logic [AREA_W-1:0]   AREA_HEIGHT_RST  = 16'hFFFF;
  localparam logic [SCOUNT_W-1:0] SENDER_COUNT_RST = 7'd0;

endpackage

`default_nettype wire

### sv/nearest_point_search.sv
// Nearest point search: position table, squared-distance scan and config registers.
// Operation: a query scans N active entries (N = sender_count, capped at the table size)
//   with busy high; the result strobe rises in the cycle after the last busy cycle.
// Throughput: one table entry per cycle, set by the single read port of the table;
//   a write request returns nothing and does not raise busy.
// Reset: control registers clear and config registers load their reset values at once;
// the table is unknown until written. done_o is a one-cycle strobe; the receiver cannot stall it.
`default_nettype none

module nearest_point_search (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // request channel
  input  wire                            start,
  output logic                           busy,
  input  wire  [nps_pkg::OP_W-1:0]        operation_i,
  input  wire  [nps_pkg::ENTRY_IDX_W-1:0] entry_index_i,
  input  wire  [nps_pkg::COORD_IN_W-1:0]  coord_x_i,
  input  wire  [nps_pkg::COORD_IN_W-1:0]  coord_y_i,
  // result channel
  output logic                           done_o,
  output logic [nps_pkg::ENTRY_IDX_W-1:0] nearest_index_o,
  output logic                           found_o,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [nps_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [nps_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nps_pkg::APB_DATA_W-1:0]  prdata,
  output logic                           pready
);

  import nps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Token kinds that travel down the scan pipeline
  typedef enum logic [1:0] {
    TK_NONE,
    TK_BOUND,
    TK_ENTRY,
    TK_LAST
  } token_e;

  typedef struct packed {
    token_e            kind;
    logic [IDX_W-1:0]  idx;
  } tag_t;

  // Configuration registers
  logic [AREA_W-1:0]   area_width_q;
  logic [AREA_W-1:0]   area_height_q;
  logic [SCOUNT_W-1:0] sender_count_q;

  // Control
  state_e            state_q;
  logic [CNT_W-1:0]  iss_q;
  logic [CNT_W-1:0]  count_q;
  tag_t              tag1_q, tag2_q, tag3_q;
  logic [DIST_W-1:0] best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              hit_q;

  // Datapath
  logic [ROW_W-1:0]      mem [MAX_ENTRIES];
  logic [ROW_W-1:0]      rd_data_q;
  logic [COORD_BITS-1:0] qx_q, qy_q;
  logic [DIFF_W-1:0]     dx_q, dy_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;

  logic                  accept;
  logic                  cfg_wr;
  reg_sel_e              reg_sel;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ROW_W-1:0]      wr_data;
  logic [CNT_W-1:0]      count_sat;
  logic [COORD_BITS-1:0] ex, ey;
  logic [COORD_BITS-1:0] adx, ady;
  logic [DIST_W-1:0]     dist_sum;

  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_sel_e'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_SEL_W]);

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_width_q   <= AREA_WIDTH_RST;
      area_height_q  <= AREA_HEIGHT_RST;
      sender_count_q <= SENDER_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_AREA_WIDTH:   area_width_q   <= pwdata[AREA_W-1:0];
        REG_AREA_HEIGHT:  area_height_q  <= pwdata[AREA_W-1:0];
        REG_SENDER_COUNT: sender_count_q <= pwdata[SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Config register reads
  always_comb begin
    unique case (reg_sel)
      REG_AREA_WIDTH:   prdata = APB_DATA_W'(area_width_q);
      REG_AREA_HEIGHT:  prdata = APB_DATA_W'(area_height_q);
      REG_SENDER_COUNT: prdata = APB_DATA_W'(sender_count_q);
      default:          prdata = '0;
    endcase
  end

  // Table write from a write request
  assign wr_en   = accept && (operation_i == OP_WRITE) &&
                   (32'(entry_index_i) < MAX_ENTRIES);
  assign wr_addr = IDX_W'(entry_index_i);
  assign wr_data = {COORD_BITS'(coord_y_i), COORD_BITS'(coord_x_i)};

  // Active entry count, capped at the table size
  assign count_sat = (32'(sender_count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(sender_count_q);

  // Position table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[iss_q[IDX_W-1:0]];
  end

  // Absolute coordinate differences against the query point
  assign ex  = rd_data_q[COORD_BITS-1:0];
  assign ey  = rd_data_q[ROW_W-1:COORD_BITS];
  assign adx = (qx_q >= ex) ? (qx_q - ex) : (ex - qx_q);
  assign ady = (qy_q >= ey) ? (qy_q - ey) : (ey - qy_q);

  // Difference and square stages; the bound token carries width and height instead
  always_ff @(posedge clk_i) begin
    if (accept) begin
      qx_q <= COORD_BITS'(coord_x_i);
      qy_q <= COORD_BITS'(coord_y_i);
    end
    if (tag1_q.kind == TK_BOUND) begin
      dx_q <= DIFF_W'(area_width_q);
      dy_q <= DIFF_W'(area_height_q);
    end else begin
      dx_q <= DIFF_W'(adx);
      dy_q <= DIFF_W'(ady);
    end
    sqx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sqy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
  end

  assign dist_sum = DIST_W'(sqx_q) + DIST_W'(sqy_q);
  assign busy     = (state_q != ST_IDLE);

  // Sequencer, token pipeline, running minimum and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      iss_q           <= '0;
      count_q         <= '0;
      tag1_q          <= '{kind: TK_NONE, idx: '0};
      tag2_q          <= '{kind: TK_NONE, idx: '0};
      tag3_q          <= '{kind: TK_NONE, idx: '0};
      best_q          <= '0;
      best_idx_q      <= '0;
      hit_q           <= 1'b0;
      done_o          <= 1'b0;
      nearest_index_o <= '0;
      found_o         <= 1'b0;
    end else begin
      done_o <= 1'b0;
      tag1_q <= '{kind: TK_NONE, idx: '0};
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;

      unique case (state_q)
        ST_IDLE: begin
          if (accept && (operation_i == OP_QUERY)) begin
            // bound token first, then the entries
            tag1_q  <= '{kind: TK_BOUND, idx: '0};
            iss_q   <= '0;
            count_q <= count_sat;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (iss_q == count_q) begin
            tag1_q  <= '{kind: TK_LAST, idx: '0};
            state_q <= ST_DRAIN;
          end else begin
            tag1_q <= '{kind: TK_ENTRY, idx: iss_q[IDX_W-1:0]};
            iss_q  <= iss_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (tag3_q.kind == TK_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Compare stage: strict less-than keeps the lowest index on a tie
      case (tag3_q.kind)
        TK_BOUND: begin
          best_q     <= dist_sum;
          best_idx_q <= '0;
          hit_q      <= 1'b0;
        end
        TK_ENTRY: begin
          if (dist_sum < best_q) begin
            best_q     <= dist_sum;
            best_idx_q <= tag3_q.idx;
            hit_q      <= 1'b1;
          end
        end
        TK_LAST: begin
          done_o          <= 1'b1;
          found_o         <= hit_q;
          nearest_index_o <= hit_q ? ENTRY_IDX_W'(best_idx_q) : '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
